// ----- rtl/tuv_pkg.sv -----
package tuv_pkg;

    localparam int POS_W  = 32;
    localparam int UV_W   = 24;
    localparam int PD_W   = POS_W + 1;
    localparam int UVD_W  = UV_W + 1;
    localparam int PROD_W = PD_W + UVD_W;
    localparam int NUM_W  = PROD_W + 1;
    localparam int DET_W  = 2 * UVD_W + 1;
    localparam int FRAC   = 16;
    localparam int OUT_W  = 32;
    localparam int THR_W  = 16;
    localparam int MAG_W  = NUM_W - FRAC + 1;

    localparam logic [THR_W-1:0] THR_RESET = 16'd43;

    // apply sign to a magnitude, saturate to the signed output range
    function automatic logic [OUT_W-1:0] sat_pack(input logic neg, input logic [MAG_W-1:0] mag);
        logic [OUT_W-1:0] res;
        if (neg) begin
            if (mag >= MAG_W'(64'h8000_0000)) begin
                res = 32'h8000_0000;
            end else begin
                res = -mag[OUT_W-1:0];
            end
        end else begin
            if (mag > MAG_W'(64'h7FFF_FFFF)) begin
                res = 32'h7FFF_FFFF;
            end else begin
                res = mag[OUT_W-1:0];
            end
        end
        return res;
    endfunction

endpackage

// ----- rtl/tuv_div.sv -----
module tuv_div
    import tuv_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic [DET_W-1:0]        i_den_mag,
    input  logic                    i_den_neg,
    output logic                    o_done,
    output logic [OUT_W-1:0]        o_result
);

    typedef enum logic [1:0] {
        D_IDLE,
        D_RUN,
        D_ROUND
    } t_dstate;

    t_dstate            r_state;
    logic [4:0]         r_cnt;
    logic [DET_W-1:0]   r_den;
    logic [DET_W-1:0]   r_rem;
    logic [OUT_W-1:0]   r_shift;
    logic [OUT_W-1:0]   r_q;
    logic               r_neg;
    logic               r_done;
    logic [OUT_W-1:0]   r_result;

    logic [NUM_W-1:0]   w_n;
    logic               w_ovf;
    logic [DET_W:0]     w_remsh;
    logic [DET_W:0]     w_sub;
    logic               w_ge;
    logic               w_round;
    logic [OUT_W:0]     w_mag;

    assign w_n     = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
    assign w_ovf   = {(DET_W + FRAC - NUM_W)'(0), w_n} >= {i_den_mag, FRAC'(0)};
    assign w_remsh = {r_rem, r_shift[OUT_W-1]};
    assign w_sub   = w_remsh - {1'b0, r_den};
    assign w_ge    = w_remsh >= {1'b0, r_den};
    assign w_round = {r_rem, 1'b0} >= {1'b0, r_den};
    assign w_mag   = {1'b0, r_q} + (OUT_W + 1)'(w_round);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_den <= i_den_mag;
                        r_neg <= i_num[NUM_W-1] ^ i_den_neg;
                        if (w_ovf) begin
                            r_result <= sat_pack(i_num[NUM_W-1] ^ i_den_neg,
                                                 MAG_W'(64'h1_0000_0000));
                            r_done   <= 1'b1;
                        end else begin
                            r_rem   <= DET_W'(w_n[NUM_W-1:FRAC]);
                            r_shift <= {w_n[FRAC-1:0], FRAC'(0)};
                            r_q     <= '0;
                            r_cnt   <= '0;
                            r_state <= D_RUN;
                        end
                    end
                end
                D_RUN: begin
                    r_rem   <= w_ge ? w_sub[DET_W-1:0] : w_remsh[DET_W-1:0];
                    r_q     <= {r_q[OUT_W-2:0], w_ge};
                    r_shift <= {r_shift[OUT_W-2:0], 1'b0};
                    r_cnt   <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_state <= D_ROUND;
                    end
                end
                D_ROUND: begin
                    r_result <= sat_pack(r_neg, MAG_W'(w_mag));
                    r_done   <= 1'b1;
                    r_state  <= D_IDLE;
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ----- rtl/triangle_uv_tangent.sv -----
// Per-triangle tangent from vertex positions and texture coordinates.
// Input stream: one vertex per item, tuser carries mesh_start. Vertices
// arrive as a triangle list; the first two of each triangle are held and
// give no result. The third vertex starts the computation and yields one
// result item (tangent xyz plus degenerate flag). For the third vertex:
// 8 products on one shared 25x33 multiplier, each through S_MUL and S_ACC,
// a decision step, then per axis either direct rounding (degenerate) or
// the radix-2 restoring divider (32 quotient bits, start, rounding and
// hand-back; an overflowing quotient saturates at start), then the load
// of the output register. s_axis_tready is low meanwhile, so no vertex
// is taken until the triangle's result is loaded.
// The result sits in an output register; while the receiver stalls it holds
// and new vertices are still taken, but the next triangle waits before its
// result load until the register is free.
// Reset clears the vertex slot, the output valid and sets
// degenerate_threshold to 43. The threshold is written over the APB port at
// address 0; the user must write it only while the block is idle (not enforced).
module triangle_uv_tangent
    import tuv_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    // position_x, position_y, position_z, tex_u, tex_v
    input  logic [143:0]   s_axis_tdata,
    // mesh_start
    input  logic [0:0]     s_axis_tuser,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    // tangent_x, tangent_y, tangent_z
    output logic [95:0]    m_axis_tdata,
    // degenerate
    output logic [0:0]     m_axis_tuser,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_DECIDE,
        S_AXIS,
        S_WAIT_DIV,
        S_FINISH
    } t_state;

    t_state                   r_state;
    logic [1:0]               r_slot;
    logic [THR_W-1:0]         r_thr;
    logic [2:0]               r_step;
    logic [1:0]               r_axis;
    logic signed [POS_W-1:0]  r_hp [6];
    logic signed [UV_W-1:0]   r_huv [4];
    logic signed [UVD_W-1:0]  r_s1, r_t1, r_s2, r_t2;
    logic signed [PD_W-1:0]   r_e1 [3];
    logic signed [PD_W-1:0]   r_e2 [3];
    logic signed [PROD_W-1:0] r_prod;
    logic signed [NUM_W-1:0]  r_acc;
    logic signed [DET_W-1:0]  r_det;
    logic signed [NUM_W-1:0]  r_num [3];
    logic                     r_degen;
    logic [DET_W-1:0]         r_den_mag;
    logic                     r_den_neg;
    logic [OUT_W-1:0]         r_res [3];
    logic                     r_out_valid;
    logic [95:0]              r_out_data;
    logic                     r_out_degen;

    logic                     w_in_acc;
    logic [1:0]               w_slot;
    logic signed [POS_W-1:0]  w_p [3];
    logic signed [UV_W-1:0]   w_u, w_v;
    logic signed [UVD_W-1:0]  w_mul_a;
    logic signed [PD_W-1:0]   w_mul_b;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [NUM_W-1:0]  w_prod_ext;
    logic signed [NUM_W-1:0]  w_acc_diff;
    logic [DET_W-1:0]         w_det_mag;
    logic signed [NUM_W-1:0]  w_num_sel;
    logic [NUM_W-1:0]         w_num_mag;
    logic [NUM_W-1:0]         w_num_rnd;
    logic [OUT_W-1:0]         w_direct;
    logic                     w_div_start;
    logic                     w_div_done;
    logic [OUT_W-1:0]         w_div_res;
    logic                     w_out_free;
    logic                     w_cfg_wr;

    assign w_p[0] = s_axis_tdata[31:0];
    assign w_p[1] = s_axis_tdata[63:32];
    assign w_p[2] = s_axis_tdata[95:64];
    assign w_u    = s_axis_tdata[119:96];
    assign w_v    = s_axis_tdata[143:120];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_slot        = (s_axis_tuser[0] || r_slot == 2'd3) ? 2'd0 : r_slot;

    assign w_cfg_wr = psel && penable && pwrite && pready && !paddr[2];
    assign pready   = 1'b1;
    assign prdata   = paddr[2] ? 32'd0 : {16'd0, r_thr};

    always_comb begin
        case (r_step)
            3'd0: begin
                w_mul_a = r_s1;
                w_mul_b = PD_W'(r_t2);
            end
            3'd1: begin
                w_mul_a = r_s2;
                w_mul_b = PD_W'(r_t1);
            end
            3'd2: begin
                w_mul_a = r_t2;
                w_mul_b = r_e1[0];
            end
            3'd3: begin
                w_mul_a = r_t1;
                w_mul_b = r_e2[0];
            end
            3'd4: begin
                w_mul_a = r_t2;
                w_mul_b = r_e1[1];
            end
            3'd5: begin
                w_mul_a = r_t1;
                w_mul_b = r_e2[1];
            end
            3'd6: begin
                w_mul_a = r_t2;
                w_mul_b = r_e1[2];
            end
            default: begin
                w_mul_a = r_t1;
                w_mul_b = r_e2[2];
            end
        endcase
    end

    assign w_prod     = w_mul_a * w_mul_b;
    assign w_prod_ext = NUM_W'(r_prod);
    assign w_acc_diff = r_acc - w_prod_ext;
    assign w_det_mag  = r_det[DET_W-1] ? DET_W'(-r_det) : DET_W'(r_det);

    always_comb begin
        case (r_axis)
            2'd0:    w_num_sel = r_num[0];
            2'd1:    w_num_sel = r_num[1];
            default: w_num_sel = r_num[2];
        endcase
    end

    assign w_num_mag   = w_num_sel[NUM_W-1] ? NUM_W'(-w_num_sel) : NUM_W'(w_num_sel);
    assign w_num_rnd   = w_num_mag + NUM_W'(32'h8000);
    assign w_direct    = sat_pack(w_num_sel[NUM_W-1], MAG_W'(w_num_rnd[NUM_W-1:FRAC]));
    assign w_div_start = (r_state == S_AXIS) && !r_degen;
    assign w_out_free  = !r_out_valid || m_axis_tready;

    tuv_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_num     (w_num_sel),
        .i_den_mag (r_den_mag),
        .i_den_neg (r_den_neg),
        .o_done    (w_div_done),
        .o_result  (w_div_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= 2'd0;
            r_thr       <= THR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                r_thr <= pwdata[THR_W-1:0];
            end
            if (r_out_valid && m_axis_tready && r_state != S_FINISH) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        case (w_slot)
                            2'd0: begin
                                r_hp[0]  <= w_p[0];
                                r_hp[1]  <= w_p[1];
                                r_hp[2]  <= w_p[2];
                                r_huv[0] <= w_u;
                                r_huv[1] <= w_v;
                                r_slot   <= 2'd1;
                            end
                            2'd1: begin
                                r_hp[3]  <= w_p[0];
                                r_hp[4]  <= w_p[1];
                                r_hp[5]  <= w_p[2];
                                r_huv[2] <= w_u;
                                r_huv[3] <= w_v;
                                r_slot   <= 2'd2;
                            end
                            default: begin
                                r_s1    <= UVD_W'(r_huv[2]) - UVD_W'(r_huv[0]);
                                r_t1    <= UVD_W'(r_huv[3]) - UVD_W'(r_huv[1]);
                                r_s2    <= UVD_W'(w_u) - UVD_W'(r_huv[0]);
                                r_t2    <= UVD_W'(w_v) - UVD_W'(r_huv[1]);
                                r_e1[0] <= PD_W'(r_hp[3]) - PD_W'(r_hp[0]);
                                r_e1[1] <= PD_W'(r_hp[4]) - PD_W'(r_hp[1]);
                                r_e1[2] <= PD_W'(r_hp[5]) - PD_W'(r_hp[2]);
                                r_e2[0] <= PD_W'(w_p[0]) - PD_W'(r_hp[0]);
                                r_e2[1] <= PD_W'(w_p[1]) - PD_W'(r_hp[1]);
                                r_e2[2] <= PD_W'(w_p[2]) - PD_W'(r_hp[2]);
                                r_slot  <= 2'd0;
                                r_step  <= 3'd0;
                                r_state <= S_MUL;
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    r_prod  <= w_prod;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (!r_step[0]) begin
                        r_acc <= w_prod_ext;
                    end else begin
                        case (r_step)
                            3'd1:    r_det    <= w_acc_diff[DET_W-1:0];
                            3'd3:    r_num[0] <= w_acc_diff;
                            3'd5:    r_num[1] <= w_acc_diff;
                            default: r_num[2] <= w_acc_diff;
                        endcase
                    end
                    if (r_step == 3'd7) begin
                        r_state <= S_DECIDE;
                    end else begin
                        r_step  <= r_step + 3'd1;
                        r_state <= S_MUL;
                    end
                end
                S_DECIDE: begin
                    r_den_mag <= w_det_mag;
                    r_den_neg <= r_det[DET_W-1];
                    r_degen   <= (w_det_mag < DET_W'(r_thr)) || (w_det_mag == '0);
                    r_axis    <= 2'd0;
                    r_state   <= S_AXIS;
                end
                S_AXIS: begin
                    if (r_degen) begin
                        case (r_axis)
                            2'd0:    r_res[0] <= w_direct;
                            2'd1:    r_res[1] <= w_direct;
                            default: r_res[2] <= w_direct;
                        endcase
                        if (r_axis == 2'd2) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_axis <= r_axis + 2'd1;
                        end
                    end else begin
                        r_state <= S_WAIT_DIV;
                    end
                end
                S_WAIT_DIV: begin
                    if (w_div_done) begin
                        case (r_axis)
                            2'd0:    r_res[0] <= w_div_res;
                            2'd1:    r_res[1] <= w_div_res;
                            default: r_res[2] <= w_div_res;
                        endcase
                        if (r_axis == 2'd2) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_axis  <= r_axis + 2'd1;
                            r_state <= S_AXIS;
                        end
                    end
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_out_data  <= {r_res[2], r_res[1], r_res[0]};
                        r_out_degen <= r_degen;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_degen;

    a_third_vertex_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_slot == 2'd2) |=> (r_state == S_MUL && r_slot == 2'd0))
        else $error("third vertex did not start the computation");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot != 2'd3)
        else $error("vertex slot out of range");

    a_div_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_WAIT_DIV && !r_degen))
        else $error("divider result arrived unexpectedly");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && r_out_valid && !m_axis_tready) |=>
            (r_state == S_FINISH && r_out_valid))
        else $error("pending result overwritten");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench
    import tuv_pkg::*;
();

    localparam logic [2:0]  THRESHOLD_ADDR = 3'd0;
    localparam logic [31:0] POS_ONE        = 32'h0001_0000;
    localparam logic [23:0] UV_ONE         = 24'h01_0000;
    localparam int          MAX_WAIT       = 18;
    localparam int          SETTLE_CYCLES  = 200;

    typedef struct packed {
        logic [OUT_W-1:0] tan_x;
        logic [OUT_W-1:0] tan_y;
        logic [OUT_W-1:0] tan_z;
        logic             degenerate;
    } t_tangent;

    class t_tangent_board;
        logic [THR_W-1:0] threshold;
        logic [1:0]       slot;
        longint           held_pos[6];
        longint           held_uv[4];
        t_tangent         expected_q[$];
        int unsigned      mismatches;

        function new();
            threshold  = THR_RESET;
            slot       = 2'd0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void flag_mismatch(string what, logic [95:0] want, logic [95:0] got);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %h, got %h", what, want, got);
        endfunction

        function logic [OUT_W-1:0] saturate(logic neg, longint unsigned mag);
            if (neg)
                return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - mag);
            return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(mag);
        endfunction

        function logic [OUT_W-1:0] round_direct(longint num);
            longint unsigned m;
            m = (num < 0) ? -num : num;
            m = (m + (64'd1 << (FRAC - 1))) >> FRAC;
            return saturate(num < 0, m);
        endfunction

        function logic [OUT_W-1:0] divide_round(longint num, longint den);
            longint unsigned n, d, q, rem;
            logic neg;
            n   = (num < 0) ? -num : num;
            d   = (den < 0) ? -den : den;
            neg = (num < 0) != (den < 0);
            q   = n / d;
            rem = n % d;
            if (q >= (64'd1 << FRAC))
                return saturate(neg, 64'h8000_0001);
            for (int i = 0; i < FRAC; i++) begin
                rem = rem << 1;
                q   = q << 1;
                if (rem >= d) begin
                    rem = rem - d;
                    q   = q | 64'd1;
                end
            end
            if (rem * 2 >= d)
                q = q + 1;
            return saturate(neg, q);
        endfunction

        function void note_vertex(logic mesh_start, logic [143:0] data);
            longint pos[3], uv[2];
            longint s1, t1, s2, t2, det, e1, e2, num;
            longint unsigned det_mag;
            logic degen;
            logic [OUT_W-1:0] axis_out[3];
            t_tangent t;
            for (int a = 0; a < 3; a++)
                pos[a] = longint'($signed(data[32*a +: 32]));
            uv[0] = longint'($signed(data[96 +: 24]));
            uv[1] = longint'($signed(data[120 +: 24]));
            if (mesh_start)
                slot = 2'd0;
            if (slot > 2'd2)
                slot = 2'd0;
            if (slot < 2'd2) begin
                for (int a = 0; a < 3; a++)
                    held_pos[slot * 3 + a] = pos[a];
                held_uv[slot * 2]     = uv[0];
                held_uv[slot * 2 + 1] = uv[1];
                slot++;
                return;
            end
            slot    = 2'd0;
            s1      = held_uv[2] - held_uv[0];
            t1      = held_uv[3] - held_uv[1];
            s2      = uv[0] - held_uv[0];
            t2      = uv[1] - held_uv[1];
            det     = s1 * t2 - s2 * t1;
            det_mag = (det < 0) ? -det : det;
            degen   = (det_mag < threshold) || (det_mag == 0);
            for (int a = 0; a < 3; a++) begin
                e1  = held_pos[3 + a] - held_pos[a];
                e2  = pos[a] - held_pos[a];
                num = t2 * e1 - t1 * e2;
                axis_out[a] = degen ? round_direct(num) : divide_round(num, det);
            end
            t.tan_x      = axis_out[0];
            t.tan_y      = axis_out[1];
            t.tan_z      = axis_out[2];
            t.degenerate = degen;
            expected_q.push_back(t);
        endfunction

        function void check_result(logic [95:0] data, logic flag);
            t_tangent want;
            if (expected_q.size() == 0) begin
                flag_mismatch("unexpected tangent", '0, data);
                return;
            end
            want = expected_q.pop_front();
            if (data[31:0] !== want.tan_x)
                flag_mismatch("tangent_x", 96'(want.tan_x), 96'(data[31:0]));
            if (data[63:32] !== want.tan_y)
                flag_mismatch("tangent_y", 96'(want.tan_y), 96'(data[63:32]));
            if (data[95:64] !== want.tan_z)
                flag_mismatch("tangent_z", 96'(want.tan_z), 96'(data[95:64]));
            if (flag !== want.degenerate)
                flag_mismatch("degenerate", 96'(want.degenerate), 96'(flag));
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // position_x, position_y, position_z, tex_u, tex_v
    logic [143:0] s_axis_tdata;
    // mesh_start
    logic [0:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // tangent_x, tangent_y, tangent_z
    logic [95:0]  m_axis_tdata;
    // degenerate
    logic [0:0]   m_axis_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    t_tangent_board board;
    logic           calm;
    int             items_sent;
    int             result_taken;
    int             stall_left;

    triangle_uv_tangent DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            board.check_result(m_axis_tdata, m_axis_tuser[0]);
            result_taken = 1;
        end
    end

    always @(negedge i_clk) begin
        if (result_taken != 0) begin
            stall_left   = calm ? 0 : $urandom_range(0, MAX_WAIT);
            result_taken = 0;
        end
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic logic [31:0] pos_span();
        logic signed [31:0] r;
        r = $urandom;
        return r >>> $urandom_range(0, 31);
    endfunction

    function automatic logic [23:0] uv_span();
        logic signed [23:0] r;
        r = 24'($urandom);
        return r >>> $urandom_range(0, 23);
    endfunction

    task automatic send_vertex(input logic mesh_start, input logic [31:0] px, py, pz,
                               input logic [23:0] u, v);
        int gap;
        gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {v, u, pz, py, px};
        s_axis_tuser  <= mesh_start;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_vertex(mesh_start, {v, u, pz, py, px});
        items_sent++;
    endtask

    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (board.pending() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_threshold(input logic [THR_W-1:0] value);
        settle();
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= THRESHOLD_ADDR;
        pwdata  <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        board.threshold = value;
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== 32'(value))
            board.flag_mismatch("threshold readback", 96'(value), 96'(prdata));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_triangle(input logic first_start);
        logic [31:0] p0[3], p1[3], p2[3];
        logic [23:0] u0, v0, u1, v1, u2, v2, du, dv;
        int mode;
        for (int a = 0; a < 3; a++) begin
            p0[a] = pos_span();
            p1[a] = p0[a] + pos_span();
            p2[a] = p0[a] + pos_span();
        end
        u0   = uv_span();
        v0   = uv_span();
        mode = $urandom_range(0, 9);
        if (mode <= 5) begin
            u1 = u0 + uv_span();
            v1 = v0 + uv_span();
            u2 = u0 + uv_span();
            v2 = v0 + uv_span();
        end else if (mode <= 7) begin
            // drive det to a small value around the threshold
            u1 = $urandom_range(0, 1) ? u0 + 24'd1 : u0 - 24'd1;
            v1 = v0;
            u2 = u0;
            v2 = v0 + ($urandom_range(0, 1) ? 24'($urandom_range(0, 100))
                                            : -24'($urandom_range(0, 100)));
        end else if (mode == 8) begin
            du = uv_span();
            dv = uv_span();
            u1 = u0 + du;
            v1 = v0 + dv;
            u2 = u0 + (du << 1);
            v2 = v0 + (dv << 1);
        end else begin
            u1 = u0;
            v1 = v0;
            u2 = u0;
            v2 = v0;
        end
        send_vertex(first_start, p0[0], p0[1], p0[2], u0, v0);
        send_vertex($urandom_range(0, 39) == 0, p1[0], p1[1], p1[2], u1, v1);
        send_vertex($urandom_range(0, 39) == 0, p2[0], p2[1], p2[2], u2, v2);
    endtask

    task automatic run_random(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target) begin
            if ($urandom_range(0, 29) == 0)
                calm = ~calm;
            if ($urandom_range(0, 14) == 0) begin
                repeat ($urandom_range(1, 2))
                    send_vertex(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                                24'($urandom), 24'($urandom));
                random_triangle(1'b1);
            end else begin
                random_triangle($urandom_range(0, 7) == 0);
            end
        end
    endtask

    initial begin
        board         = new();
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        calm          = 1'b0;
        items_sent    = 0;
        result_taken  = 0;
        stall_left    = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // unit tangent along x
        send_vertex(1'b1, 32'd0, 32'd0, 32'd0, 24'd0, 24'd0);
        send_vertex(1'b0, POS_ONE, 32'd0, 32'd0, UV_ONE, 24'd0);
        send_vertex(1'b0, 32'd0, POS_ONE, 32'd0, 24'd0, UV_ONE);
        // field extremes, saturating quotient
        send_vertex(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 24'h80_0000, 24'h7F_FFFF);
        send_vertex(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    24'h7F_FFFF, 24'h80_0000);
        send_vertex(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 24'd0, 24'd1);
        // zero determinant
        send_vertex(1'b0, 32'h0000_1234, 32'hFFFF_0000, 32'd5, 24'h00_1000, 24'h00_2000);
        send_vertex(1'b0, 32'h0123_4567, 32'd9, 32'hFFFF_FFFF, 24'h00_1000, 24'h00_2000);
        send_vertex(1'b0, 32'h8000_0000, 32'd77, 32'd3, 24'h00_1000, 24'h00_2000);
        // determinant just under the reset threshold
        send_vertex(1'b0, 32'd0, 32'd0, 32'd0, 24'd0, 24'd0);
        send_vertex(1'b0, POS_ONE, -POS_ONE, 32'd3, 24'd1, 24'd0);
        send_vertex(1'b0, 32'd7, 32'd9, -32'd5, 24'd0, 24'd40);
        // rounding ties on the direct path
        send_vertex(1'b0, 32'd0, 32'd0, 32'd0, 24'd0, 24'd0);
        send_vertex(1'b0, 32'h0000_8000, 32'hFFFF_8000, 32'h0001_8000, 24'd1, 24'd0);
        send_vertex(1'b0, 32'd11, -32'd13, 32'd17, 24'd0, 24'd1);
        // incomplete triangle, dropped by the next mesh start
        send_vertex(1'b1, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333, 24'h44_4444, 24'd5);
        send_vertex(1'b0, 32'hCCCC_CCCC, 32'd6, 32'd7, 24'd8, 24'h99_9999);
        // negative determinant with rounded quotient
        send_vertex(1'b1, 32'd0, 32'd0, 32'd0, 24'd0, 24'd0);
        send_vertex(1'b0, 32'd5, POS_ONE, -32'd9, 24'd0, UV_ONE);
        send_vertex(1'b0, POS_ONE, -2 * POS_ONE, 32'h0000_5555, 24'd3 * UV_ONE, 24'd0);
        run_random(500);

        set_threshold(16'd0);
        send_vertex(1'b1, 32'd3, 32'd4, 32'd5, 24'h00_0700, 24'h00_0800);
        send_vertex(1'b0, POS_ONE, 32'd4, -POS_ONE, 24'h00_0700, 24'h00_0800);
        send_vertex(1'b0, 32'd0, POS_ONE, 32'd5, 24'h00_0700, 24'h00_0800);
        send_vertex(1'b0, 32'd0, 32'd0, 32'd0, 24'd0, 24'd0);
        send_vertex(1'b0, 32'h0000_8000, 32'hFFFF_8000, 32'd1, 24'd1, 24'd0);
        send_vertex(1'b0, 32'd2, 32'd2, 32'd2, 24'd0, 24'd1);
        run_random(350);

        set_threshold(16'hFFFF);
        run_random(300);
        set_threshold(16'($urandom_range(1, 16'hFFFE)));
        run_random(250);
        set_threshold(THR_RESET);
        run_random(250);

        settle();
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
